>>> hw/rtl/stepper_trapezoid_ramp_macros.svh
// ---------------------------------------------------------------------------
// Stepper ramp assertion macros
// Shared property forms for the checker of the stepper ramp generator.
// ---------------------------------------------------------------------------
`ifndef STEPPER_TRAPEZOID_RAMP_MACROS_SVH
`define STEPPER_TRAPEZOID_RAMP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define STP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stepper ramp check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define STP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stepper ramp check failed");

`endif

>>> hw/rtl/stp_pkg.sv
// ---------------------------------------------------------------------------
// Stepper ramp package
// Widths, codes and shared types of the trapezoidal stepper ramp generator.
// ---------------------------------------------------------------------------
`default_nettype none

package stp_pkg;

	localparam int STEP_BITS = 24;
	localparam int FRAC_BITS = 16;
	localparam int US_W      = 24;
	localparam int DELAY_W   = US_W + FRAC_BITS;
	localparam int MIN_W     = 20;
	localparam int RATE_W    = 16;
	localparam int SC_W      = 24;
	localparam int POS_W     = 32;
	localparam int MODE_W    = 3;
	localparam int ADDR_W    = 5;
	localparam int IDX_W     = 3;
	localparam int PROD_W    = STEP_BITS + RATE_W;
	localparam int DVD_W     = (DELAY_W + 1 > PROD_W + 1) ? DELAY_W + 1 : PROD_W + 1;
	localparam int DVS_W     = (STEP_BITS + 2 > RATE_W + 1) ? STEP_BITS + 2 : RATE_W + 1;
	localparam int CNT_W     = $clog2(DVD_W + 1);
	localparam int MAG_W     = (POS_W + 1 > STEP_BITS + 1) ? POS_W + 1 : STEP_BITS + 1;

	localparam logic [MODE_W-1:0] MODE_TIMER    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_MOVE_REL = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ROTATE   = 3'd2;
	localparam logic [MODE_W-1:0] MODE_STOP     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_MOVE_ABS = 3'd4;
	localparam logic [MODE_W-1:0] MODE_ZERO     = 3'd5;

	localparam logic [IDX_W-1:0] REG_MIN_DELAY   = 3'd0;
	localparam logic [IDX_W-1:0] REG_FIRST_DELAY = 3'd1;
	localparam logic [IDX_W-1:0] REG_ACCEL       = 3'd2;
	localparam logic [IDX_W-1:0] REG_DECEL       = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEPS_SPEED = 3'd4;

	localparam logic [MIN_W-1:0] MIN_DELAY_RESET = 20'd2500;

	typedef enum logic [1:0] {
		PH_STOP   = 2'd0,
		PH_ACCEL  = 2'd1,
		PH_CRUISE = 2'd2,
		PH_DECEL  = 2'd3
	} phase_t;

	typedef struct packed {
		logic [MIN_W-1:0]  min_delay;
		logic [US_W-1:0]   first_delay;
		logic [RATE_W-1:0] accel;
		logic [RATE_W-1:0] decel;
		logic [US_W-1:0]   steps_to_speed;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_START_MOVE,
		OP_START_ROT,
		OP_MUL_NS,
		OP_NS_ZERO,
		OP_DIV_NS,
		OP_SET_NS,
		OP_DIV_SUB,
		OP_SET_SUB,
		OP_DIV_RAMP,
		OP_SET_RAMP,
		OP_CRUISE,
		OP_STOP,
		OP_ZERO,
		OP_ISSUE,
		OP_IDLE_OUT
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_MUL,
		S_NS_GO,
		S_NS_WAIT,
		S_SUB_CHK,
		S_SUB_WAIT,
		S_RAMP_WAIT,
		S_ISSUE,
		S_IDLE_OUT
	} state_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              running;
		logic              move_ok;
		logic              speed_set;
		logic              den_zero;
		logic              sub_needed;
		logic              ramping;
		logic              div_done;
		logic              out_free;
	} dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/stepper_trapezoid_ramp.sv
// ---------------------------------------------------------------------------
// Stepper trapezoidal ramp generator
// Linear speed ramp profile for a stepper motor, one result per command.
// ---------------------------------------------------------------------------
// Usage: commands and timer expiries enter on the slave stream, one transaction
// per item, with the mode in s_tuser. Each item yields exactly one result
// transaction on the master stream carrying the step pulse, the direction,
// the delay to the next step in microseconds and the position and phase.
// A timer item while accelerating or decelerating runs one division through
// the shared restoring divider; a cruise timer item, stop, zero and ignored
// items run none. Starting a move plans the ramp-down point with up to two
// divisions. One item is processed at a time. The result register decouples
// the two streams: a held result does not block acceptance of the next item,
// which waits only before writing its own result while the receiver stalls.
// Reset clears the motion state and loads the register defaults (minimum
// delay 2500 us, everything else zero). The user must write registers over
// the APB-style port only while the block is idle; the block itself does not
// enforce this.
// ---------------------------------------------------------------------------
`default_nettype none

module stepper_trapezoid_ramp (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// slave stream
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	// step_count [23:0], rotate_direction [24], target_position [56:25]
	input  wire logic [63:0]                s_tdata,
	// mode [2:0]
	input  wire logic [stp_pkg::MODE_W-1:0] s_tuser,
	// master stream
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	// step_pulse [0], dir_out [1], next_delay_us [25:2], delay_valid [26],
	// current_position [58:27], phase [60:59]
	output logic      [63:0]                m_tdata,
	// configuration port
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [stp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic      [31:0]                prdata,
	output logic                            pready
);
	import stp_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// Register file; the user must keep settings static while items are in flight (unenforced).
	stp_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The controller only sequences; all arithmetic lives in the datapath.
	stp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the motion state and owns the result register.
	stp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire

>>> hw/rtl/stp_cfg.sv
// ---------------------------------------------------------------------------
// Stepper ramp register file
// APB-style register block holding the profile settings.
// ---------------------------------------------------------------------------
`default_nettype none

module stp_cfg (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      psel,
	input  wire logic                      penable,
	input  wire logic                      pwrite,
	input  wire logic [stp_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]               pwdata,
	output logic      [31:0]               prdata,
	output logic                           pready,
	output stp_pkg::cfg_t                  cfg
);
	import stp_pkg::*;

	cfg_t             cfg_q;
	logic [IDX_W-1:0] idx;
	logic             wr;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_delay      <= MIN_DELAY_RESET;
			cfg_q.first_delay    <= '0;
			cfg_q.accel          <= '0;
			cfg_q.decel          <= '0;
			cfg_q.steps_to_speed <= '0;
		end else if (wr) begin
			case (idx)
				REG_MIN_DELAY:   cfg_q.min_delay      <= pwdata[MIN_W-1:0];
				REG_FIRST_DELAY: cfg_q.first_delay    <= pwdata[US_W-1:0];
				REG_ACCEL:       cfg_q.accel          <= pwdata[RATE_W-1:0];
				REG_DECEL:       cfg_q.decel          <= pwdata[RATE_W-1:0];
				REG_STEPS_SPEED: cfg_q.steps_to_speed <= pwdata[US_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_DELAY:   prdata = 32'(cfg_q.min_delay);
			REG_FIRST_DELAY: prdata = 32'(cfg_q.first_delay);
			REG_ACCEL:       prdata = 32'(cfg_q.accel);
			REG_DECEL:       prdata = 32'(cfg_q.decel);
			REG_STEPS_SPEED: prdata = 32'(cfg_q.steps_to_speed);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/stp_div.sv
// ---------------------------------------------------------------------------
// Stepper ramp divider
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module stp_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [stp_pkg::DVD_W-1:0]  dividend,
	input  wire logic [stp_pkg::DVS_W-1:0]  divisor,
	output logic      [stp_pkg::DVD_W-1:0]  quotient,
	output logic                            done
);
	import stp_pkg::*;

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             ge;
	logic [DVS_W:0]   diff;

	assign trial    = {rem_q, quo_q[DVD_W-1]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign diff     = trial - {1'b0, dvs_q};
	assign quotient = quo_q;
	assign done     = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/stp_dp.sv
// ---------------------------------------------------------------------------
// Stepper ramp datapath
// Motion state, delay arithmetic, shared divider and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module stp_dp (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire stp_pkg::cfg_t       cfg,
	input  wire stp_pkg::dp_cmd_t    cmd,
	output stp_pkg::dp_status_t      status,
	input  wire logic [63:0]         s_tdata,
	input  wire logic [stp_pkg::MODE_W-1:0] s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic      [63:0]         m_tdata
);
	import stp_pkg::*;

	localparam logic [STEP_BITS-1:0] STEP_MAX  = '1;
	localparam logic [DELAY_W-1:0]   DELAY_MAX = '1;

	// captured command
	logic [MODE_W-1:0]    mode_q;
	logic [SC_W-1:0]      sc_q;
	logic                 rdir_q;
	logic [POS_W-1:0]     tp_q;
	// motion state
	phase_t               phase_q;
	logic [STEP_BITS-1:0] step_q;
	logic [STEP_BITS-1:0] total_q;
	logic [STEP_BITS-1:0] ns_q;
	logic [DELAY_W-1:0]   delay_q;
	logic [POS_W-1:0]     pos_q;
	logic                 dir_q;
	logic [PROD_W-1:0]    prod_q;
	// result register
	logic                 ovalid_q;
	logic                 opulse_q;
	logic                 odir_q;
	logic [US_W-1:0]      odelay_q;
	logic                 odvalid_q;
	logic [POS_W-1:0]     opos_q;
	phase_t               ophase_q;

	logic [SC_W:0]        mag_rel;
	logic [POS_W:0]       diff;
	logic [MAG_W-1:0]     mag;
	logic                 mag_neg;
	logic [STEP_BITS-1:0] total_sat;
	logic [STEP_BITS-1:0] nts;
	logic [RATE_W:0]      den;
	logic [STEP_BITS-1:0] rem;
	logic                 div_start;
	logic [DVD_W-1:0]     dvd;
	logic [DVS_W-1:0]     dvs;
	logic [DVD_W-1:0]     quot;
	logic                 div_done;
	logic [DELAY_W-1:0]   d_acc;
	logic [DELAY_W+1:0]   d_dec;
	logic                 decel_hit;
	logic [STEP_BITS-1:0] step_inc;
	logic                 last_step;
	logic [DELAY_W-1:0]   min_fixed;
	logic                 use_cruise;

	always_comb begin
		mag_rel = sc_q[SC_W-1] ? ({1'b1, {SC_W{1'b0}}} - {1'b0, sc_q}) : {1'b0, sc_q};
		diff    = {tp_q[POS_W-1], tp_q} - {pos_q[POS_W-1], pos_q};
		if (mode_q == MODE_MOVE_ABS) begin
			mag_neg = diff[POS_W];
			mag     = MAG_W'(diff[POS_W] ? (~diff + 1'b1) : diff);
		end else begin
			mag_neg = sc_q[SC_W-1];
			mag     = MAG_W'(mag_rel);
		end
		total_sat = (mag > MAG_W'(STEP_MAX)) ? STEP_MAX : mag[STEP_BITS-1:0];
	end

	assign nts        = (cfg.accel == '0) ? '0 : STEP_BITS'(cfg.steps_to_speed);
	assign den        = {1'b0, cfg.decel} + {1'b0, cfg.accel};
	assign rem        = total_q - step_q;
	assign min_fixed  = DELAY_W'({cfg.min_delay, {FRAC_BITS{1'b0}}});
	assign use_cruise = (cfg.first_delay <= US_W'(cfg.min_delay)) || (cfg.accel == '0);
	assign decel_hit  = (total_q != '0) && (cfg.decel != '0) && (step_q >= ns_q);
	assign step_inc   = (step_q == STEP_MAX) ? step_q : step_q + 1'b1;
	assign last_step  = (total_q != '0) && (step_inc >= total_q);
	assign d_acc      = delay_q - quot[DELAY_W-1:0];
	assign d_dec      = (DELAY_W+2)'(delay_q) + (DELAY_W+2)'(quot);

	always_comb begin
		div_start = 1'b0;
		dvd       = DVD_W'({delay_q, 1'b0});
		dvs       = DVS_W'(den);
		case (cmd.op)
			OP_DIV_NS: begin
				div_start = 1'b1;
				dvd       = DVD_W'(prod_q);
			end
			OP_DIV_SUB: begin
				div_start = 1'b1;
				dvd       = DVD_W'(prod_q) + DVD_W'(cfg.decel) - 1'b1;
				dvs       = DVS_W'(cfg.decel);
			end
			OP_DIV_RAMP: begin
				div_start = 1'b1;
				dvs = (phase_q == PH_ACCEL) ? DVS_W'({step_q, 2'b01}) : DVS_W'({rem, 2'b01});
			end
			default: ;
		endcase
	end

	stp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.quotient (quot),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_STOP;
			step_q   <= '0;
			total_q  <= '0;
			ns_q     <= '0;
			delay_q  <= '0;
			pos_q    <= '0;
			dir_q    <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && m_tready)
				ovalid_q <= 1'b0;
			case (cmd.op)
				OP_START_MOVE, OP_START_ROT: begin
					step_q <= '0;
					if (cmd.op == OP_START_MOVE) begin
						dir_q   <= !mag_neg;
						total_q <= total_sat;
					end else begin
						dir_q   <= rdir_q;
						total_q <= '0;
					end
					if (use_cruise) begin
						delay_q <= min_fixed;
						phase_q <= PH_CRUISE;
					end else begin
						delay_q <= {cfg.first_delay, {FRAC_BITS{1'b0}}};
						phase_q <= PH_ACCEL;
					end
				end
				OP_NS_ZERO: ns_q <= '0;
				OP_SET_NS:  ns_q <= quot[STEP_BITS-1:0];
				OP_SET_SUB: begin
					if (quot >= DVD_W'(total_q))
						ns_q <= '0;
					else
						ns_q <= total_q - quot[STEP_BITS-1:0];
				end
				OP_SET_RAMP: begin
					if (phase_q == PH_ACCEL) begin
						if (d_acc[DELAY_W-1:FRAC_BITS] <= US_W'(cfg.min_delay)) begin
							delay_q <= min_fixed;
							phase_q <= decel_hit ? PH_DECEL : PH_CRUISE;
						end else begin
							delay_q <= d_acc;
							phase_q <= decel_hit ? PH_DECEL : PH_ACCEL;
						end
					end else begin
						delay_q <= (d_dec > (DELAY_W+2)'(DELAY_MAX)) ? DELAY_MAX :
							d_dec[DELAY_W-1:0];
					end
				end
				OP_CRUISE: begin
					if (decel_hit)
						phase_q <= PH_DECEL;
				end
				OP_STOP: begin
					phase_q <= PH_STOP;
					total_q <= '0;
				end
				OP_ZERO: pos_q <= '0;
				OP_ISSUE: begin
					ovalid_q <= 1'b1;
					step_q   <= step_inc;
					pos_q    <= dir_q ? pos_q + 1'b1 : pos_q - 1'b1;
					if (last_step) begin
						phase_q <= PH_STOP;
						total_q <= '0;
					end
				end
				OP_IDLE_OUT: ovalid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_LOAD) begin
			mode_q <= s_tuser;
			sc_q   <= s_tdata[SC_W-1:0];
			rdir_q <= s_tdata[SC_W];
			tp_q   <= s_tdata[SC_W+POS_W:SC_W+1];
		end
		if (cmd.op == OP_MUL_NS)
			prod_q <= total_q * cfg.decel;
		else if (cmd.op == OP_SET_NS)
			prod_q <= nts * cfg.accel;
		if (cmd.op == OP_ISSUE) begin
			opulse_q  <= 1'b1;
			odir_q    <= dir_q;
			odelay_q  <= last_step ? '0 : delay_q[DELAY_W-1:FRAC_BITS];
			odvalid_q <= !last_step;
			opos_q    <= dir_q ? pos_q + 1'b1 : pos_q - 1'b1;
			ophase_q  <= last_step ? PH_STOP : phase_q;
		end else if (cmd.op == OP_IDLE_OUT) begin
			opulse_q  <= 1'b0;
			odir_q    <= dir_q;
			odelay_q  <= '0;
			odvalid_q <= 1'b0;
			opos_q    <= pos_q;
			ophase_q  <= phase_q;
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {3'b000, ophase_q, opos_q, odvalid_q, odelay_q, odir_q, opulse_q};

	always_comb begin
		status.mode       = mode_q;
		status.running    = phase_q != PH_STOP;
		status.move_ok    = mag != '0;
		status.speed_set  = cfg.min_delay != '0;
		status.den_zero   = den == '0;
		status.sub_needed = (ns_q > nts) && (cfg.decel != '0);
		status.ramping    = (phase_q == PH_ACCEL) || (phase_q == PH_DECEL);
		status.div_done   = div_done;
		status.out_free   = !ovalid_q || m_tready;
	end

endmodule

`default_nettype wire

>>> hw/rtl/stp_ctrl.sv
// ---------------------------------------------------------------------------
// Stepper ramp controller
// Sequences command decode, ramp-down planning, divisions and result issue.
// ---------------------------------------------------------------------------
`default_nettype none

module stp_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire stp_pkg::dp_status_t status,
	output stp_pkg::dp_cmd_t        cmd
);
	import stp_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid)
					state_d = S_DECODE;
			end
			S_DECODE: begin
				state_d = S_IDLE_OUT;
				case (status.mode)
					MODE_TIMER: begin
						if (status.running)
							state_d = status.ramping ? S_RAMP_WAIT : S_ISSUE;
					end
					MODE_MOVE_REL, MODE_MOVE_ABS: begin
						if (!status.running && status.move_ok && status.speed_set)
							state_d = S_MUL;
					end
					MODE_ROTATE: begin
						if (!status.running && status.speed_set)
							state_d = S_ISSUE;
					end
					default: ;
				endcase
			end
			S_MUL:       state_d = S_NS_GO;
			S_NS_GO:     state_d = status.den_zero ? S_ISSUE : S_NS_WAIT;
			S_NS_WAIT: begin
				if (status.div_done)
					state_d = S_SUB_CHK;
			end
			S_SUB_CHK:   state_d = status.sub_needed ? S_SUB_WAIT : S_ISSUE;
			S_SUB_WAIT: begin
				if (status.div_done)
					state_d = S_ISSUE;
			end
			S_RAMP_WAIT: begin
				if (status.div_done)
					state_d = S_ISSUE;
			end
			S_ISSUE, S_IDLE_OUT: begin
				if (status.out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NONE;
		s_tready = state_q == S_IDLE;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid)
					cmd.op = OP_LOAD;
			end
			S_DECODE: begin
				case (status.mode)
					MODE_TIMER: begin
						if (status.running)
							cmd.op = status.ramping ? OP_DIV_RAMP : OP_CRUISE;
					end
					MODE_MOVE_REL, MODE_MOVE_ABS: begin
						if (!status.running && status.move_ok && status.speed_set)
							cmd.op = OP_START_MOVE;
					end
					MODE_ROTATE: begin
						if (!status.running && status.speed_set)
							cmd.op = OP_START_ROT;
					end
					MODE_STOP: cmd.op = OP_STOP;
					MODE_ZERO: cmd.op = OP_ZERO;
					default: ;
				endcase
			end
			S_MUL:   cmd.op = OP_MUL_NS;
			S_NS_GO: cmd.op = status.den_zero ? OP_NS_ZERO : OP_DIV_NS;
			S_NS_WAIT: begin
				if (status.div_done)
					cmd.op = OP_SET_NS;
			end
			S_SUB_CHK: begin
				if (status.sub_needed)
					cmd.op = OP_DIV_SUB;
			end
			S_SUB_WAIT: begin
				if (status.div_done)
					cmd.op = OP_SET_SUB;
			end
			S_RAMP_WAIT: begin
				if (status.div_done)
					cmd.op = OP_SET_RAMP;
			end
			S_ISSUE: begin
				if (status.out_free)
					cmd.op = OP_ISSUE;
			end
			S_IDLE_OUT: begin
				if (status.out_free)
					cmd.op = OP_IDLE_OUT;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/stp_chk.sv
// ---------------------------------------------------------------------------
// Stepper ramp checker
// Port-level properties of the stepper ramp generator, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

`include "stepper_trapezoid_ramp_macros.svh"

module stp_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata
);

	// A held result keeps its contents until taken.
	`STP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// One item in work at a time: no second acceptance right after one.
	`STP_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)

	// Without a step the timer is never armed and the delay reads zero.
	`STP_ASSERT_IMPL(a_no_step, m_tvalid && !m_tdata[0],
		!m_tdata[26] && (m_tdata[25:2] == 24'd0))

	// An armed timer means the motor is still moving.
	`STP_ASSERT_IMPL(a_armed_moving, m_tvalid && m_tdata[26], m_tdata[60:59] != 2'd0)

	// A step that leaves the timer unarmed is the last one and stops the motor.
	`STP_ASSERT_IMPL(a_last_stops, m_tvalid && m_tdata[0] && !m_tdata[26],
		m_tdata[60:59] == 2'd0)

endmodule

bind stepper_trapezoid_ramp stp_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
